// ===== rtl/xeu_pkg.sv =====
// shared types, constants and character helpers for the xml entity unescaper
package xeu_pkg;

    // entity delimiters
    localparam logic [7:0] AMP_CHAR  = 8'h26;
    localparam logic [7:0] SEMI_CHAR = 8'h3B;

    // characters given by the known names
    localparam logic [7:0] QUOTE_CHAR = 8'h22;
    localparam logic [7:0] APOS_CHAR  = 8'h27;
    localparam logic [7:0] LT_CHAR    = 8'h3C;
    localparam logic [7:0] GT_CHAR    = 8'h3E;

    localparam int NAME_COUNT = 5;
    localparam int NAME_AMP   = 0;
    localparam int NAME_APOS  = 1;
    localparam int NAME_LT    = 2;
    localparam int NAME_GT    = 3;
    localparam int NAME_QUOT  = 4;

    localparam logic [2:0] LEN_AMP  = 3'd3;
    localparam logic [2:0] LEN_APOS = 3'd4;
    localparam logic [2:0] LEN_LT   = 3'd2;
    localparam logic [2:0] LEN_GT   = 3'd2;
    localparam logic [2:0] LEN_QUOT = 3'd4;
    localparam logic [2:0] LEN_MAX  = 3'd7;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] text_byte;
        logic       string_end;
    } in_t;

    typedef struct packed {
        logic [7:0] plain_byte;
        logic       byte_present;
        logic       final_result;
    } out_t;

    typedef enum logic [1:0] {
        OP_PLAIN,
        OP_OPEN,
        OP_NAME,
        OP_CLOSE
    } op_t;

    typedef enum logic [2:0] {
        NUM_SPACE,
        NUM_PLUS,
        NUM_MINUS,
        NUM_DIGIT,
        NUM_OTHER
    } num_class_t;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_DIGITS,
        PH_STOP
    } phase_t;

    // one classified request passed from front to back
    typedef struct packed {
        op_t                   op;
        logic [7:0]            data;
        logic                  last;
        logic [2:0]            name_len;
        logic                  first_char;
        logic [NAME_COUNT-1:0] hit;
        num_class_t            num_class;
        logic [3:0]            digit;
    } cmd_t;

    // names that still match with this byte at this position
    function automatic logic [NAME_COUNT-1:0] name_hit(input logic [2:0] pos,
                                                      input logic [7:0] b);
        logic [NAME_COUNT-1:0] h;
        h = '0;
        h[NAME_AMP]  = (pos == 3'd0 && b == "a") || (pos == 3'd1 && b == "m")
                    || (pos == 3'd2 && b == "p");
        h[NAME_APOS] = (pos == 3'd0 && b == "a") || (pos == 3'd1 && b == "p")
                    || (pos == 3'd2 && b == "o") || (pos == 3'd3 && b == "s");
        h[NAME_LT]   = (pos == 3'd0 && b == "l") || (pos == 3'd1 && b == "t");
        h[NAME_GT]   = (pos == 3'd0 && b == "g") || (pos == 3'd1 && b == "t");
        h[NAME_QUOT] = (pos == 3'd0 && b == "q") || (pos == 3'd1 && b == "u")
                    || (pos == 3'd2 && b == "o") || (pos == 3'd3 && b == "t");
        return h;
    endfunction

    function automatic num_class_t classify(input logic [7:0] b);
        num_class_t c;
        if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) begin
            c = NUM_SPACE;
        end
        else if (b == "+") begin
            c = NUM_PLUS;
        end
        else if (b == "-") begin
            c = NUM_MINUS;
        end
        else if (b >= "0" && b <= "9") begin
            c = NUM_DIGIT;
        end
        else begin
            c = NUM_OTHER;
        end
        return c;
    endfunction

endpackage

// ===== rtl/xeu_front.sv =====
// front end: tracks entity framing and classifies each byte into a request
module xeu_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          src_valid,
    input  xeu_pkg::in_t  src_data,
    input  logic          queue_full,
    output logic          src_stall,
    output logic          push,
    output xeu_pkg::cmd_t push_data
);

    logic       inside_reg;
    logic       inside_next;
    logic [2:0] len_reg;
    logic [2:0] len_next;
    logic       accept;
    logic [7:0] b;
    logic [7:0] digit_full;

    assign src_stall  = queue_full;
    assign accept     = src_valid && !queue_full;
    assign push       = accept;
    assign b          = src_data.text_byte;
    assign digit_full = b - 8'h30;

    always_comb
    begin
        inside_next          = inside_reg;
        len_next             = len_reg;
        push_data.data       = b;
        push_data.last       = src_data.string_end;
        push_data.name_len   = len_reg;
        push_data.first_char = (len_reg == 3'd0);
        push_data.hit        = xeu_pkg::name_hit(len_reg, b);
        push_data.num_class  = xeu_pkg::classify(b);
        push_data.digit      = digit_full[3:0];
        push_data.op         = xeu_pkg::OP_PLAIN;
        if (!inside_reg) begin
            if (b == xeu_pkg::AMP_CHAR) begin
                push_data.op = xeu_pkg::OP_OPEN;
                inside_next  = 1'b1;
                len_next     = 3'd0;
            end
        end
        else if (b == xeu_pkg::SEMI_CHAR) begin
            push_data.op = xeu_pkg::OP_CLOSE;
            inside_next  = 1'b0;
            len_next     = 3'd0;
        end
        else begin
            push_data.op = xeu_pkg::OP_NAME;
            len_next     = (len_reg == xeu_pkg::LEN_MAX) ? len_reg : len_reg + 3'd1;
        end
        if (src_data.string_end) begin
            inside_next = 1'b0;
            len_next    = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            inside_reg <= 1'b0;
            len_reg    <= 3'd0;
        end
        else if (accept) begin
            inside_reg <= inside_next;
            len_reg    <= len_next;
        end
    end

endmodule

// ===== rtl/xeu_queue.sv =====
// two-entry request queue between front and back
module xeu_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  xeu_pkg::cmd_t push_data,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output xeu_pkg::cmd_t head
);

    xeu_pkg::cmd_t                 mem_reg [xeu_pkg::QUEUE_DEPTH];
    logic [xeu_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [xeu_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [xeu_pkg::QCNT_W-1:0]    count_reg;
    logic [xeu_pkg::QCNT_W-1:0]    count_next;

    localparam logic [xeu_pkg::QPTR_W-1:0] PTR_LAST = xeu_pkg::QPTR_W'(xeu_pkg::QUEUE_DEPTH - 1);
    localparam logic [xeu_pkg::QCNT_W-1:0] CNT_FULL = xeu_pkg::QCNT_W'(xeu_pkg::QUEUE_DEPTH);

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// ===== rtl/xeu_back.sv =====
// back end: name matching, number accumulation and result register
module xeu_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          empty,
    input  xeu_pkg::cmd_t head,
    output logic          pop,
    output logic          res_valid,
    output xeu_pkg::out_t res_data,
    input  logic          res_stall
);

    logic [xeu_pkg::NAME_COUNT-1:0] match_reg;
    logic [xeu_pkg::NAME_COUNT-1:0] match_next;
    xeu_pkg::phase_t                phase_reg;
    xeu_pkg::phase_t                phase_next;
    logic                           neg_reg;
    logic                           neg_next;
    logic [7:0]                     value_reg;
    logic [7:0]                     value_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    xeu_pkg::out_t                  out_data_reg;
    xeu_pkg::out_t                  out_data_next;
    logic                           load;
    logic                           present;
    logic [7:0]                     ch;
    logic [7:0]                     decoded;
    logic [7:0]                     times_ten;
    logic [7:0]                     digit_ext;

    assign load      = !out_valid_reg || !res_stall;
    assign pop       = !empty && load;
    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;
    assign digit_ext = {4'd0, head.digit};
    assign times_ten = {value_reg[4:0], 3'd0} + {value_reg[6:0], 1'b0};

    // known names first, in table order, then the number
    always_comb
    begin
        if (match_reg[xeu_pkg::NAME_AMP] && head.name_len == xeu_pkg::LEN_AMP) begin
            decoded = xeu_pkg::AMP_CHAR;
        end
        else if (match_reg[xeu_pkg::NAME_APOS] && head.name_len == xeu_pkg::LEN_APOS) begin
            decoded = xeu_pkg::APOS_CHAR;
        end
        else if (match_reg[xeu_pkg::NAME_LT] && head.name_len == xeu_pkg::LEN_LT) begin
            decoded = xeu_pkg::LT_CHAR;
        end
        else if (match_reg[xeu_pkg::NAME_GT] && head.name_len == xeu_pkg::LEN_GT) begin
            decoded = xeu_pkg::GT_CHAR;
        end
        else if (match_reg[xeu_pkg::NAME_QUOT] && head.name_len == xeu_pkg::LEN_QUOT) begin
            decoded = xeu_pkg::QUOTE_CHAR;
        end
        else if (neg_reg) begin
            decoded = 8'd0 - value_reg;
        end
        else begin
            decoded = value_reg;
        end
    end

    always_comb
    begin
        match_next = match_reg;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        value_next = value_reg;
        present    = 1'b0;
        ch         = 8'd0;
        unique case (head.op)
            xeu_pkg::OP_PLAIN:
            begin
                present = 1'b1;
                ch      = head.data;
            end
            xeu_pkg::OP_OPEN:
            begin
                match_next = '1;
                phase_next = xeu_pkg::PH_LEAD;
                neg_next   = 1'b0;
                value_next = 8'd0;
            end
            xeu_pkg::OP_CLOSE:
            begin
                present    = 1'b1;
                ch         = decoded;
                match_next = '1;
                phase_next = xeu_pkg::PH_LEAD;
                neg_next   = 1'b0;
                value_next = 8'd0;
            end
            xeu_pkg::OP_NAME:
            begin
                match_next = match_reg & head.hit;
                if (!head.first_char) begin
                    if (phase_reg == xeu_pkg::PH_LEAD) begin
                        case (head.num_class)
                            xeu_pkg::NUM_SPACE: ;
                            xeu_pkg::NUM_PLUS:  phase_next = xeu_pkg::PH_DIGITS;
                            xeu_pkg::NUM_MINUS:
                            begin
                                neg_next   = 1'b1;
                                phase_next = xeu_pkg::PH_DIGITS;
                            end
                            xeu_pkg::NUM_DIGIT:
                            begin
                                value_next = digit_ext;
                                phase_next = xeu_pkg::PH_DIGITS;
                            end
                            default:            phase_next = xeu_pkg::PH_STOP;
                        endcase
                    end
                    else if (phase_reg == xeu_pkg::PH_DIGITS) begin
                        if (head.num_class == xeu_pkg::NUM_DIGIT) begin
                            value_next = times_ten + digit_ext;
                        end
                        else begin
                            phase_next = xeu_pkg::PH_STOP;
                        end
                    end
                end
            end
            default: ;
        endcase
        // string end drops any open entity
        if (head.last) begin
            match_next = '1;
            phase_next = xeu_pkg::PH_LEAD;
            neg_next   = 1'b0;
            value_next = 8'd0;
        end
        out_data_next.plain_byte   = ch;
        out_data_next.byte_present = present;
        out_data_next.final_result = head.last;
        out_valid_next = out_valid_reg && res_stall;
        if (pop) begin
            out_valid_next = present || head.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            match_reg     <= '1;
            phase_reg     <= xeu_pkg::PH_LEAD;
            neg_reg       <= 1'b0;
            value_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg <= out_valid_next;
            if (pop) begin
                match_reg <= match_next;
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                value_reg <= value_next;
            end
        end
    end

endmodule

// ===== rtl/xml_entity_unescaper.sv =====
// top level of the xml entity unescaper: front, request queue and back
//
//  channel | direction | payload          | handshake
//  src     | in        | xeu_pkg::in_t    | src_valid / src_stall
//  res     | out       | xeu_pkg::out_t   | res_valid / res_stall
//
// one request per cycle sustained while nothing stalls; the front classifies each
// request into the queue, and the back decodes it into the result register
// rst_n clears framing, match and number state and empties the queue
// src_stall rises only when the two-entry queue is full
// a stalled result holds in the result register while the back keeps it
module xml_entity_unescaper (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          src_valid,
    output logic          src_stall,
    input  xeu_pkg::in_t  src_data,
    output logic          res_valid,
    input  logic          res_stall,
    output xeu_pkg::out_t res_data
);

    // classified requests from front to back
    logic          push;
    xeu_pkg::cmd_t push_data;
    logic          pop;
    logic          queue_full;
    logic          queue_empty;
    xeu_pkg::cmd_t head;

    // front: entity open/close and name position, per-byte classification
    xeu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_data   (src_data),
        .queue_full (queue_full),
        .src_stall  (src_stall),
        .push       (push),
        .push_data  (push_data)
    );

    // short queue so each side can stall on its own
    xeu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (queue_full),
        .empty     (queue_empty),
        .head      (head)
    );

    // back: name matching, atoi-style number and the result register
    xeu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (queue_empty),
        .head      (head),
        .pop       (pop),
        .res_valid (res_valid),
        .res_data  (res_data),
        .res_stall (res_stall)
    );

endmodule

// ===== rtl/xeu_checker.sv =====
// port-level checks for the xml entity unescaper, bound to the top level
module xeu_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          src_valid,
    input logic          src_stall,
    input xeu_pkg::in_t  src_data,
    input logic          res_valid,
    input logic          res_stall,
    input xeu_pkg::out_t res_data
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(res_data))
        else $error("result payload changed while stalled");

    // an empty result carries a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.byte_present |-> res_data.plain_byte == 8'd0)
        else $error("empty result with nonzero byte");

    // every result carries a byte or closes the string
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.byte_present || res_data.final_result)
        else $error("result with neither byte nor end mark");

endmodule

bind xml_entity_unescaper xeu_checker u_xeu_checker (.*);
